>>> rtl/rv64ex_pkg.sv
// Shared types and constants for the RV64I integer execute pipeline.
// Used by the decode, execute and writeback stages and by the top level.
package rv64ex_pkg;

  localparam int unsigned XLEN       = 64;
  localparam int unsigned ILEN       = 32;
  localparam int unsigned REG_IDX_W  = 5;
  localparam int unsigned SHAMT_W    = 6;
  localparam int unsigned IN_DATA_W  = 288;
  localparam int unsigned OUT_DATA_W = 144;

  // Major opcodes, instruction bits 6:2
  localparam logic [4:0] MAJ_OP_IMM    = 5'h04;
  localparam logic [4:0] MAJ_AUIPC     = 5'h05;
  localparam logic [4:0] MAJ_OP_IMM_32 = 5'h06;
  localparam logic [4:0] MAJ_OP        = 5'h0C;
  localparam logic [4:0] MAJ_LUI       = 5'h0D;
  localparam logic [4:0] MAJ_OP_32     = 5'h0E;
  localparam logic [4:0] MAJ_BRANCH    = 5'h18;
  localparam logic [4:0] MAJ_JALR      = 5'h19;
  localparam logic [4:0] MAJ_JAL       = 5'h1B;

  localparam logic [6:0] FUNCT7_MULDIV = 7'h01;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BRSV0 = 3'd2;
  localparam logic [2:0] F3_BRSV1 = 3'd3;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  typedef enum logic [3:0] {
    KIND_ALU,
    KIND_LUI,
    KIND_AUIPC,
    KIND_JAL,
    KIND_JALR,
    KIND_BRANCH,
    KIND_ILLEGAL,
    KIND_MULDIV,
    KIND_UNSUP
  } kind_e;

  // Decode -> execute
  typedef struct packed {
    kind_e                  kind;
    logic [REG_IDX_W-1:0]   rd;
    logic [2:0]             funct3;
    logic                   is_w;
    logic                   sub_en;
    logic                   sra_en;
    logic [SHAMT_W-1:0]     shamt;
    logic [XLEN-1:0]        a_z;   // operand a, zero-extended for W forms
    logic [XLEN-1:0]        a_s;   // operand a, sign-extended for W forms
    logic [XLEN-1:0]        b_z;
    logic [XLEN-1:0]        b_s;
    logic [XLEN-1:0]        base;  // address adder inputs
    logic [XLEN-1:0]        imm;
    logic [XLEN-1:0]        link;
  } dec_t;

  // Execute -> writeback
  typedef struct packed {
    kind_e                  kind;
    logic [REG_IDX_W-1:0]   rd;
    logic                   is_w;
    logic                   taken;
    logic [XLEN-1:0]        alu_res;
    logic [XLEN-1:0]        sum;
    logic [XLEN-1:0]        link;
  } ex_t;

  // Result word, field order matches the master tdata packing
  typedef struct packed {
    logic                   unsupported;
    logic                   to_muldiv;
    logic                   illegal;
    logic [XLEN-1:0]        target_pc;
    logic                   pc_write;
    logic [XLEN-1:0]        rd_value;
    logic [REG_IDX_W-1:0]   rd_index;
    logic                   rd_write;
  } res_t;

endpackage

>>> rtl/rv64ex_decode.sv
// Stage 1: instruction decode, immediate build and operand preparation.
// Depends on rv64ex_pkg.
module rv64ex_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rv64ex_pkg::ILEN-1:0]  insn_i,
  input  logic [rv64ex_pkg::XLEN-1:0]  insn_pc_i,
  input  logic [rv64ex_pkg::XLEN-1:0]  next_pc_i,
  input  logic [rv64ex_pkg::XLEN-1:0]  rs1_value_i,
  input  logic [rv64ex_pkg::XLEN-1:0]  rs2_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rv64ex_pkg::dec_t             out_data_o
);

  logic                         valid_q;
  rv64ex_pkg::dec_t             data_q, data_d;
  logic [4:0]                   maj;
  logic [2:0]                   f3;
  logic                         reg_form;
  logic [rv64ex_pkg::XLEN-1:0]  i_imm, u_imm, j_imm, b_imm, rhs;

  assign maj      = insn_i[6:2];
  assign f3       = insn_i[14:12];
  assign reg_form = maj[3];

  assign i_imm = {{52{insn_i[31]}}, insn_i[31:20]};
  assign u_imm = {{32{insn_i[31]}}, insn_i[31:12], 12'b0};
  assign j_imm = {{43{insn_i[31]}}, insn_i[31], insn_i[19:12], insn_i[20],
                  insn_i[30:21], 1'b0};
  assign b_imm = {{51{insn_i[31]}}, insn_i[31], insn_i[7], insn_i[30:25],
                  insn_i[11:8], 1'b0};
  assign rhs   = reg_form ? rs2_value_i : i_imm;

  always_comb begin
    data_d        = '0;
    data_d.kind   = rv64ex_pkg::KIND_UNSUP;
    data_d.rd     = insn_i[11:7];
    data_d.funct3 = f3;
    data_d.link   = next_pc_i;
    data_d.a_z    = rs1_value_i;
    data_d.a_s    = rs1_value_i;
    data_d.b_z    = rs2_value_i;
    data_d.b_s    = rs2_value_i;
    data_d.base   = insn_pc_i;
    data_d.imm    = b_imm;
    case (maj)
      rv64ex_pkg::MAJ_OP, rv64ex_pkg::MAJ_OP_32,
      rv64ex_pkg::MAJ_OP_IMM, rv64ex_pkg::MAJ_OP_IMM_32: begin
        if (reg_form && insn_i[31:25] == rv64ex_pkg::FUNCT7_MULDIV) begin
          data_d.kind = rv64ex_pkg::KIND_MULDIV;
        end else begin
          data_d.kind   = rv64ex_pkg::KIND_ALU;
          data_d.is_w   = maj[1];
          data_d.sub_en = insn_i[30] && reg_form && (f3 == rv64ex_pkg::F3_ADD);
          data_d.sra_en = insn_i[30];
          if (maj[1]) begin
            data_d.a_z   = {32'b0, rs1_value_i[31:0]};
            data_d.a_s   = {{32{rs1_value_i[31]}}, rs1_value_i[31:0]};
            data_d.b_z   = {32'b0, rhs[31:0]};
            data_d.b_s   = {{32{rhs[31]}}, rhs[31:0]};
            data_d.shamt = {1'b0, rhs[4:0]};
          end else begin
            data_d.b_z   = rhs;
            data_d.b_s   = rhs;
            data_d.shamt = rhs[5:0];
          end
        end
      end
      rv64ex_pkg::MAJ_LUI: begin
        data_d.kind = rv64ex_pkg::KIND_LUI;
        data_d.base = '0;
        data_d.imm  = u_imm;
      end
      rv64ex_pkg::MAJ_AUIPC: begin
        data_d.kind = rv64ex_pkg::KIND_AUIPC;
        data_d.imm  = u_imm;
      end
      rv64ex_pkg::MAJ_JAL: begin
        data_d.kind = rv64ex_pkg::KIND_JAL;
        data_d.imm  = j_imm;
      end
      rv64ex_pkg::MAJ_JALR: begin
        data_d.kind = rv64ex_pkg::KIND_JALR;
        data_d.base = rs1_value_i;
        data_d.imm  = i_imm;
      end
      rv64ex_pkg::MAJ_BRANCH: begin
        if (f3 inside {rv64ex_pkg::F3_BRSV0, rv64ex_pkg::F3_BRSV1}) begin
          data_d.kind = rv64ex_pkg::KIND_ILLEGAL;
        end else begin
          data_d.kind = rv64ex_pkg::KIND_BRANCH;
        end
      end
      default: begin
        data_d.kind = rv64ex_pkg::KIND_UNSUP;
      end
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/rv64ex_execute.sv
// Stage 2: ALU, branch compare and address adder.
// Depends on rv64ex_pkg.
module rv64ex_execute (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rv64ex_pkg::dec_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rv64ex_pkg::ex_t    out_data_o
);

  logic                         valid_q;
  rv64ex_pkg::ex_t              data_q, data_d;
  logic                         lt_s, lt_u, eq;
  logic [rv64ex_pkg::XLEN-1:0]  res;

  assign lt_s = $signed(in_data_i.a_s) < $signed(in_data_i.b_s);
  assign lt_u = in_data_i.a_z < in_data_i.b_z;
  assign eq   = in_data_i.a_z == in_data_i.b_z;

  always_comb begin
    case (in_data_i.funct3)
      rv64ex_pkg::F3_ADD:  res = in_data_i.sub_en ? in_data_i.a_z - in_data_i.b_z
                                                  : in_data_i.a_z + in_data_i.b_z;
      rv64ex_pkg::F3_SLL:  res = in_data_i.a_z << in_data_i.shamt;
      rv64ex_pkg::F3_SLT:  res = {63'b0, lt_s};
      rv64ex_pkg::F3_SLTU: res = {63'b0, lt_u};
      rv64ex_pkg::F3_XOR:  res = in_data_i.a_z ^ in_data_i.b_z;
      rv64ex_pkg::F3_SR:   res = in_data_i.sra_en
                                 ? $unsigned($signed(in_data_i.a_s) >>> in_data_i.shamt)
                                 : in_data_i.a_z >> in_data_i.shamt;
      rv64ex_pkg::F3_OR:   res = in_data_i.a_z | in_data_i.b_z;
      default:             res = in_data_i.a_z & in_data_i.b_z;
    endcase
  end

  always_comb begin
    data_d         = '0;
    data_d.kind    = in_data_i.kind;
    data_d.rd      = in_data_i.rd;
    data_d.is_w    = in_data_i.is_w;
    data_d.alu_res = res;
    data_d.sum     = in_data_i.base + in_data_i.imm;
    data_d.link    = in_data_i.link;
    case (in_data_i.funct3)
      rv64ex_pkg::F3_BEQ:  data_d.taken = eq;
      rv64ex_pkg::F3_BNE:  data_d.taken = !eq;
      rv64ex_pkg::F3_BLT:  data_d.taken = lt_s;
      rv64ex_pkg::F3_BGE:  data_d.taken = !lt_s;
      rv64ex_pkg::F3_BLTU: data_d.taken = lt_u;
      rv64ex_pkg::F3_BGEU: data_d.taken = !lt_u;
      default:             data_d.taken = 1'b0;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/rv64ex_writeback.sv
// Stage 3: result formatting and the output register.
// Depends on rv64ex_pkg.
module rv64ex_writeback (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rv64ex_pkg::ex_t    in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rv64ex_pkg::res_t   out_data_o
);

  logic              valid_q;
  rv64ex_pkg::res_t  data_q, data_d;

  always_comb begin
    data_d = '0;
    case (in_data_i.kind)
      rv64ex_pkg::KIND_ALU: begin
        data_d.rd_write = 1'b1;
        data_d.rd_index = in_data_i.rd;
        data_d.rd_value = in_data_i.is_w
                          ? {{32{in_data_i.alu_res[31]}}, in_data_i.alu_res[31:0]}
                          : in_data_i.alu_res;
      end
      rv64ex_pkg::KIND_LUI, rv64ex_pkg::KIND_AUIPC: begin
        data_d.rd_write = 1'b1;
        data_d.rd_index = in_data_i.rd;
        data_d.rd_value = in_data_i.sum;
      end
      rv64ex_pkg::KIND_JAL: begin
        data_d.rd_write  = 1'b1;
        data_d.rd_index  = in_data_i.rd;
        data_d.rd_value  = in_data_i.link;
        data_d.pc_write  = 1'b1;
        data_d.target_pc = in_data_i.sum;
      end
      rv64ex_pkg::KIND_JALR: begin
        data_d.rd_write  = 1'b1;
        data_d.rd_index  = in_data_i.rd;
        data_d.rd_value  = in_data_i.link;
        data_d.pc_write  = 1'b1;
        data_d.target_pc = {in_data_i.sum[rv64ex_pkg::XLEN-1:1], 1'b0};
      end
      rv64ex_pkg::KIND_BRANCH: begin
        data_d.pc_write  = in_data_i.taken;
        data_d.target_pc = in_data_i.taken ? in_data_i.sum : '0;
      end
      rv64ex_pkg::KIND_ILLEGAL: data_d.illegal   = 1'b1;
      rv64ex_pkg::KIND_MULDIV:  data_d.to_muldiv = 1'b1;
      default:                  data_d.unsupported = 1'b1;
    endcase
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // Flags are exclusive and suppress every other field
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $onehot0({data_q.illegal, data_q.to_muldiv, data_q.unsupported}))
    else $error("more than one exception flag set");

  a_flag_clears_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.illegal || data_q.to_muldiv || data_q.unsupported)
    |-> !data_q.rd_write && !data_q.pc_write)
    else $error("flagged word also writes rd or pc");

  a_rd_zero_when_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.rd_write |-> data_q.rd_index == '0 && data_q.rd_value == '0)
    else $error("rd fields not cleared");

  a_target_zero_when_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !data_q.pc_write |-> data_q.target_pc == '0)
    else $error("target_pc not cleared");

endmodule

>>> rtl/rv64i_integer_execute_core.sv
// Top level of the RV64I integer execute pipeline: ports and stage wiring.
// Depends on rv64ex_pkg, rv64ex_decode, rv64ex_execute and rv64ex_writeback.
//
//   channel   dir   handshake                        payload
//   s_axis    in    s_axis_tvalid_i/s_axis_tready_o  insn, insn_pc, next_pc, rs1, rs2
//   m_axis    out   m_axis_tvalid_o/m_axis_tready_i  rd/pc writes and exception flags
//
// An accepted input word reaches the valid output word through these registers:
// decode register, execute register (ALU, branch compare, address adder),
// output register. One word is accepted per cycle when the sink keeps up.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage takes a new word when it is empty or its word moves on, so a
// stall at m_axis backs up stage by stage without losing or repeating a word.
module rv64i_integer_execute_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Slave side
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: insn[31:0], insn_pc[95:32], next_pc[159:96],
  //        rs1_value[223:160], rs2_value[287:224]
  input  logic [rv64ex_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // Master side
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: rd_write[0], rd_index[5:1], rd_value[69:6], pc_write[70],
  //        target_pc[134:71], illegal[135], to_muldiv[136], unsupported[137],
  //        zero fill [143:138]
  output logic [rv64ex_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  logic              dec_valid, dec_ready;
  logic              ex_valid, ex_ready;
  rv64ex_pkg::dec_t  dec_data;
  rv64ex_pkg::ex_t   ex_data;
  rv64ex_pkg::res_t  res_data;

  // Decode: split the slave word and register the decoded control
  rv64ex_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .insn_i      (s_axis_tdata_i[31:0]),
    .insn_pc_i   (s_axis_tdata_i[95:32]),
    .next_pc_i   (s_axis_tdata_i[159:96]),
    .rs1_value_i (s_axis_tdata_i[223:160]),
    .rs2_value_i (s_axis_tdata_i[287:224]),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_data_o  (dec_data)
  );

  // Execute: ALU result, branch decision and address sum
  rv64ex_execute u_execute (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_data_i   (dec_data),
    .out_valid_o (ex_valid),
    .out_ready_i (ex_ready),
    .out_data_o  (ex_data)
  );

  // Writeback: format the result word and hold it for the sink
  rv64ex_writeback u_writeback (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ex_valid),
    .in_ready_o  (ex_ready),
    .in_data_i   (ex_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res_data)
  );

  // Pad the packed result up to whole bytes
  assign m_axis_tdata_o = {6'b0, res_data};

  // Input back-pressure only arises from a full pipe behind a waiting output
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i && ex_valid && dec_valid)
    else $error("input stalled with room in the pipeline");

endmodule
